/* rtl/core/dpmq_pkg.sv */
// ----------------------------------------------------------------------------
// dpmq_pkg
// Shared constants and types for the deduplicating priority message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dpmq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SEEN_DEPTH  = 32;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int SW = $clog2(SEEN_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SCW = $clog2(SEEN_DEPTH + 1);

    // operation codes
    localparam logic [2:0] OP_ENQ   = 3'd0;
    localparam logic [2:0] OP_DEQ   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_AGE   = 3'd4;
    localparam logic [2:0] OP_STATS = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_LOOP  = 3'd1;
    localparam logic [2:0] ST_DUP   = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    // counter indexes
    localparam logic [2:0] CNT_ENQ  = 3'd0;
    localparam logic [2:0] CNT_DEQ  = 3'd1;
    localparam logic [2:0] CNT_DUP  = 3'd2;
    localparam logic [2:0] CNT_LOOP = 3'd3;
    localparam logic [2:0] CNT_OVER = 3'd4;

    localparam logic [7:0] PRIO_TOP = 8'd255;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] src_id;
        logic [7:0]  ttl;
        logic        in_path;
        logic [63:0] payload;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_src_id;
        logic [7:0]  out_ttl;
        logic [63:0] out_payload;
        logic [4:0]  queue_count;
        logic [31:0] stat_value;
        logic        last;
    } t_rsp;

endpackage

`default_nettype wire

/* rtl/core/dpmq_if.sv */
// ----------------------------------------------------------------------------
// dpmq_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpmq_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/dpmq_seen.sv */
// ----------------------------------------------------------------------------
// dpmq_seen
// Seen cache memory: scanned one entry per cycle for lookup and aging; free
// entries are found from the valid bits. Valid bits live in flip-flops; data lives in a sync RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module dpmq_seen
    import dpmq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // scan read
    input  wire logic [SW-1:0]     i_rd_addr,
    output logic                   o_rd_valid,
    output logic [31:0]            o_rd_sender,
    output logic [7:0]             o_rd_ttl,
    output logic [31:0]            o_rd_time,
    // write of a new record
    input  wire logic              i_wr_en,
    input  wire logic [SW-1:0]     i_wr_addr,
    input  wire logic [31:0]       i_wr_sender,
    input  wire logic [7:0]        i_wr_ttl,
    input  wire logic [31:0]       i_wr_time,
    // invalidate one, or all
    input  wire logic              i_inv_en,
    input  wire logic [SW-1:0]     i_inv_addr,
    input  wire logic              i_clr_all,
    output logic [SEEN_DEPTH-1:0]  o_valid
);

    logic [71:0]           r_mem [SEEN_DEPTH];
    logic [71:0]           r_rd;
    logic [SEEN_DEPTH-1:0] r_valid;
    logic                  r_rd_valid;

    // data RAM
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_sender, i_wr_ttl, i_wr_time};
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr_all) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_rd_addr];
            if (i_inv_en) begin
                r_valid[i_inv_addr] <= 1'b0;
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_valid  = r_rd_valid;
    assign o_rd_sender = r_rd[71:40];
    assign o_rd_ttl    = r_rd[39:32];
    assign o_rd_time   = r_rd[31:0];
    assign o_valid     = r_valid;

endmodule

`default_nettype wire

/* rtl/core/dpmq_slots.sv */
// ----------------------------------------------------------------------------
// dpmq_slots
// Queue slot memory: valid bits in flip-flops, message data in a sync RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module dpmq_slots
    import dpmq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [QW-1:0]      i_rd_addr,
    output logic [31:0]             o_rd_sender,
    output logic [7:0]              o_rd_ttl,
    output logic [63:0]             o_rd_body,
    input  wire logic               i_wr_en,
    input  wire logic [QW-1:0]      i_wr_addr,
    input  wire logic [31:0]        i_wr_sender,
    input  wire logic [7:0]         i_wr_ttl,
    input  wire logic [63:0]        i_wr_body,
    input  wire logic               i_inv_en,
    input  wire logic [QW-1:0]      i_inv_addr,
    input  wire logic               i_clr_all,
    output logic [QUEUE_DEPTH-1:0]  o_valid
);

    logic [103:0]           r_mem [QUEUE_DEPTH];
    logic [103:0]           r_rd;
    logic [QUEUE_DEPTH-1:0] r_valid;

    // data RAM
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_sender, i_wr_ttl, i_wr_body};
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr_all) begin
            r_valid <= '0;
        end else begin
            if (i_inv_en) begin
                r_valid[i_inv_addr] <= 1'b0;
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_sender = r_rd[103:72];
    assign o_rd_ttl    = r_rd[71:64];
    assign o_rd_body   = r_rd[63:0];
    assign o_valid     = r_valid;

endmodule

`default_nettype wire

/* rtl/core/dedup_priority_message_queue_unit.sv */
// ----------------------------------------------------------------------------
// dedup_priority_message_queue_unit
// Priority message queue with a duplicate filter (seen cache).
//
// Usage: requests enter on the i_req channel (valid/ready), one at a time;
// results leave on o_rsp. Each request yields one result, read statistics
// yields five, the final one marked by last. The age limit register sits
// at byte address 0 of the APB port.
// Flow: an enqueue walks the seen cache one entry per cycle; dequeue/peek walk
// the slot priorities and then read the winning slot; age clean walks the seen
// cache; clear and the other operations answer without a scan. The scan over
// the seen RAM, one read per cycle, sets the rate. A new request is taken
// once the last result of the previous one has left the output register.
// Reset clears all valid bits, counters and the age limit at once; no clearing
// pass is needed. When the receiver stalls the result register holds and
// no new request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_priority_message_queue_unit
    import dpmq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    dpmq_if.sink          i_req,
    dpmq_if.source        o_rsp,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ESCAN  = 4'd1;
    localparam logic [3:0] S_EWRITE = 4'd2;
    localparam logic [3:0] S_PSCAN  = 4'd3;
    localparam logic [3:0] S_PREAD  = 4'd4;
    localparam logic [3:0] S_PDONE  = 4'd5;
    localparam logic [3:0] S_ASCAN  = 4'd6;
    localparam logic [3:0] S_STATS  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // slot priorities are small enough to keep in flops alongside valid bits
    logic [7:0]  r_prio [QUEUE_DEPTH];

    logic [3:0]  r_state;
    t_req        r_req;
    t_rsp        r_rsp;
    logic        r_out_v;
    logic [31:0] r_max_age;
    logic [31:0] r_cnt [5];
    logic [QCW-1:0] r_entry_count;
    logic [SCW-1:0] r_seen_entries;
    logic [SW:0] r_idx;       // scan index, one wider than needed to end
    logic        r_hit;
    logic        r_best_v;
    logic [QW-1:0] r_best;
    logic [2:0]  r_stat_i;

    // memory hookups
    logic [SW-1:0] seen_rd_addr;
    logic          seen_rd_valid;
    logic [31:0]   seen_rd_sender;
    logic [7:0]    seen_rd_ttl;
    logic [31:0]   seen_rd_time;
    logic          seen_wr_en;
    logic [SW-1:0] seen_wr_addr;
    logic          seen_inv_en;
    logic [SW-1:0] seen_inv_addr;
    logic          clr_all;
    logic [SEEN_DEPTH-1:0] seen_valid;
    logic [QW-1:0] slot_rd_addr;
    logic [31:0]   slot_rd_sender;
    logic [7:0]    slot_rd_ttl;
    logic [63:0]   slot_rd_body;
    logic          slot_wr_en;
    logic [QW-1:0] slot_wr_addr;
    logic          slot_inv_en;
    logic [QUEUE_DEPTH-1:0] slot_valid;
    logic [QW-1:0] slot_free;
    logic          slot_free_v;
    logic [SW-1:0] seen_free;
    logic          seen_free_v;
    logic          accept;
    logic          out_take;
    logic [31:0]   age;

    assign accept   = i_req.valid && i_req.ready;
    assign out_take = r_out_v && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_v;
    assign o_rsp.valid = r_out_v;
    assign o_rsp.payload = r_rsp;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_max_age : 32'd0;

    // lowest free slot and seen entry (priority encoders over valid bits)
    always_comb begin
        slot_free   = '0;
        slot_free_v = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!slot_valid[i]) begin
                slot_free   = QW'(i);
                slot_free_v = 1'b1;
            end
        end
        seen_free   = '0;
        seen_free_v = 1'b0;
        for (int i = SEEN_DEPTH - 1; i >= 0; i--) begin
            if (!seen_valid[i]) begin
                seen_free   = SW'(i);
                seen_free_v = 1'b1;
            end
        end
    end

    assign seen_rd_addr = r_idx[SW-1:0];
    assign slot_rd_addr = r_best;
    assign age = r_req.now_ms - seen_rd_time;

    // memory control
    always_comb begin
        seen_wr_en    = 1'b0;
        seen_wr_addr  = seen_free;
        seen_inv_en   = 1'b0;
        seen_inv_addr = r_idx[SW-1:0] - SW'(1);
        slot_wr_en    = 1'b0;
        slot_wr_addr  = slot_free;
        slot_inv_en   = 1'b0;
        clr_all       = 1'b0;
        case (r_state)
            S_EWRITE: begin
                if (!r_hit && r_entry_count < QCW'(QUEUE_DEPTH) && slot_free_v) begin
                    slot_wr_en = 1'b1;
                    seen_wr_en = (r_seen_entries < SCW'(SEEN_DEPTH)) && seen_free_v;
                end
            end
            S_ASCAN: begin
                seen_inv_en = (r_idx != '0) && seen_rd_valid && (age > r_max_age);
            end
            S_PDONE: begin
                slot_inv_en = r_best_v && (r_req.operation == OP_DEQ);
            end
            S_IDLE: begin
                clr_all = accept && (i_req.payload.operation == OP_CLEAR);
            end
            default: ;
        endcase
    end

    dpmq_seen u_seen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (seen_rd_addr),
        .o_rd_valid  (seen_rd_valid),
        .o_rd_sender (seen_rd_sender),
        .o_rd_ttl    (seen_rd_ttl),
        .o_rd_time   (seen_rd_time),
        .i_wr_en     (seen_wr_en),
        .i_wr_addr   (seen_wr_addr),
        .i_wr_sender (r_req.src_id),
        .i_wr_ttl    (r_req.ttl),
        .i_wr_time   (r_req.now_ms),
        .i_inv_en    (seen_inv_en),
        .i_inv_addr  (seen_inv_addr),
        .i_clr_all   (clr_all),
        .o_valid     (seen_valid)
    );

    dpmq_slots u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (slot_rd_addr),
        .o_rd_sender (slot_rd_sender),
        .o_rd_ttl    (slot_rd_ttl),
        .o_rd_body   (slot_rd_body),
        .i_wr_en     (slot_wr_en),
        .i_wr_addr   (slot_wr_addr),
        .i_wr_sender (r_req.src_id),
        .i_wr_ttl    (r_req.ttl),
        .i_wr_body   (r_req.payload),
        .i_inv_en    (slot_inv_en),
        .i_inv_addr  (r_best),
        .i_clr_all   (clr_all),
        .o_valid     (slot_valid)
    );

    // priority shadow for the slot scan
    always_ff @(posedge i_clk) begin
        if (slot_wr_en) begin
            r_prio[slot_wr_addr] <= PRIO_TOP - r_req.ttl;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_max_age <= pwdata;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_v        <= 1'b0;
            r_entry_count  <= '0;
            r_seen_entries <= '0;
            for (int i = 0; i < 5; i++) begin
                r_cnt[i] <= '0;
            end
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_best_v <= 1'b0;
            r_best   <= '0;
            r_stat_i <= '0;
        end else begin
            // the stats state reloads the result register itself
            if (out_take && r_state != S_STATS) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= i_req.payload;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_best_v <= 1'b0;
                        r_best   <= '0;
                        r_rsp.out_src_id  <= '0;
                        r_rsp.out_ttl     <= '0;
                        r_rsp.out_payload <= '0;
                        r_rsp.stat_value  <= '0;
                        r_rsp.last        <= 1'b1;
                        case (i_req.payload.operation)
                            OP_ENQ: begin
                                if (i_req.payload.in_path) begin
                                    r_cnt[CNT_LOOP] <= r_cnt[CNT_LOOP] + 32'd1;
                                    r_rsp.status      <= ST_LOOP;
                                    r_rsp.queue_count <= 5'(r_entry_count);
                                    r_out_v <= 1'b1;
                                end else begin
                                    r_state <= S_ESCAN;
                                end
                            end
                            OP_DEQ, OP_PEEK: begin
                                r_rsp.status <= ST_OK;
                                r_state      <= S_PSCAN;
                            end
                            OP_CLEAR: begin
                                r_entry_count     <= '0;
                                r_seen_entries    <= '0;
                                r_rsp.status      <= ST_OK;
                                r_rsp.queue_count <= '0;
                                r_out_v <= 1'b1;
                            end
                            OP_AGE: begin
                                r_rsp.status <= ST_OK;
                                r_state      <= S_ASCAN;
                            end
                            OP_STATS: begin
                                r_rsp.status <= ST_OK;
                                r_stat_i     <= '0;
                                r_state      <= S_STATS;
                            end
                            default: begin
                                r_rsp.status      <= ST_OK;
                                r_rsp.queue_count <= 5'(r_entry_count);
                                r_out_v <= 1'b1;
                            end
                        endcase
                    end
                end
                // seen lookup: the compare sees the entry read at the previous index
                S_ESCAN: begin
                    if (r_idx != '0 && seen_rd_valid && seen_rd_sender == r_req.src_id
                            && seen_rd_ttl == r_req.ttl) begin
                        r_hit <= 1'b1;
                    end
                    if (r_idx == (SW+1)'(SEEN_DEPTH)) begin
                        r_state <= S_EWRITE;
                    end else begin
                        r_idx <= r_idx + (SW+1)'(1);
                    end
                end
                S_EWRITE: begin
                    if (r_hit || (seen_rd_valid && seen_rd_sender == r_req.src_id
                            && seen_rd_ttl == r_req.ttl)) begin
                        r_cnt[CNT_DUP] <= r_cnt[CNT_DUP] + 32'd1;
                        r_rsp.status   <= ST_DUP;
                        r_rsp.queue_count <= 5'(r_entry_count);
                        r_state <= S_IDLE;
                        r_out_v <= 1'b1;
                    end else if (slot_wr_en) begin
                        r_entry_count <= r_entry_count + QCW'(1);
                        if (seen_wr_en) begin
                            r_seen_entries <= r_seen_entries + SCW'(1);
                        end
                        r_cnt[CNT_ENQ] <= r_cnt[CNT_ENQ] + 32'd1;
                        r_rsp.status   <= ST_OK;
                        r_rsp.queue_count <= 5'(r_entry_count + QCW'(1));
                        r_state <= S_IDLE;
                        r_out_v <= 1'b1;
                    end else begin
                        r_cnt[CNT_OVER] <= r_cnt[CNT_OVER] + 32'd1;
                        r_rsp.status   <= ST_OVER;
                        r_rsp.queue_count <= 5'(r_entry_count);
                        r_state <= S_IDLE;
                        r_out_v <= 1'b1;
                    end
                end
                // priority scan, one slot per cycle
                S_PSCAN: begin
                    if (slot_valid[r_idx[QW-1:0]] &&
                            (!r_best_v || r_prio[r_idx[QW-1:0]] < r_prio[r_best])) begin
                        r_best_v <= 1'b1;
                        r_best   <= r_idx[QW-1:0];
                    end
                    if (r_idx == (SW+1)'(QUEUE_DEPTH - 1)) begin
                        r_state <= S_PREAD;
                    end else begin
                        r_idx <= r_idx + (SW+1)'(1);
                    end
                end
                S_PREAD: r_state <= S_PDONE;
                S_PDONE: begin
                    if (r_best_v) begin
                        r_rsp.out_src_id  <= slot_rd_sender;
                        r_rsp.out_ttl     <= slot_rd_ttl;
                        r_rsp.out_payload <= slot_rd_body;
                        if (r_req.operation == OP_DEQ) begin
                            r_entry_count  <= r_entry_count - QCW'(1);
                            r_cnt[CNT_DEQ] <= r_cnt[CNT_DEQ] + 32'd1;
                            r_rsp.queue_count <= 5'(r_entry_count - QCW'(1));
                        end else begin
                            r_rsp.queue_count <= 5'(r_entry_count);
                        end
                    end else begin
                        r_rsp.status      <= ST_EMPTY;
                        r_rsp.queue_count <= 5'(r_entry_count);
                    end
                    r_state <= S_IDLE;
                    r_out_v <= 1'b1;
                end
                // aging scan; invalidate targets the entry read at the previous index
                S_ASCAN: begin
                    if (seen_inv_en && r_seen_entries != '0) begin
                        r_seen_entries <= r_seen_entries - SCW'(1);
                    end
                    if (r_idx == (SW+1)'(SEEN_DEPTH)) begin
                        r_rsp.queue_count <= 5'(r_entry_count);
                        r_state <= S_IDLE;
                        r_out_v <= 1'b1;
                    end else begin
                        r_idx <= r_idx + (SW+1)'(1);
                    end
                end
                S_STATS: begin
                    if (!r_out_v || out_take) begin
                        r_rsp.stat_value  <= r_cnt[r_stat_i];
                        r_rsp.queue_count <= 5'(r_entry_count);
                        r_rsp.last <= (r_stat_i == CNT_OVER);
                        r_out_v    <= 1'b1;
                        if (r_stat_i == CNT_OVER) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_stat_i <= r_stat_i + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
